// ----- rtl/smau_pkg.sv -----
`default_nettype none

package smau_pkg;

   // geometry
   localparam int MAX_DIM   = 8;
   localparam int IDX_W     = 3;
   localparam int DIM_CFG_W = 4;
   localparam int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

   // number formats
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int ACC_W  = 40;
   localparam int PROD_W = 2 * DATA_W;
   localparam int TERM_W = PROD_W - FRAC_W;

   // request modes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUN     = 2'd2;

   // operation codes
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
   localparam logic [OP_W-1:0] OP_MUL       = 3'd1;
   localparam logic [OP_W-1:0] OP_ELEMENT   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCALE     = 3'd3;
   localparam logic [OP_W-1:0] OP_TRANSPOSE = 3'd4;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 2'd2;
   localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sd65536;

   // per-term tag traveling down the datapath
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             first;  // first term of a result element
      logic             fin;    // final term: element completes here
      logic             last;   // final element of the matrix
   } tag_type;

endpackage

`default_nettype wire

// ----- rtl/smau_ram.sv -----
`default_nettype none

module smau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/smau_mac.sv -----
`default_nettype none

module smau_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_vld,
   input  smau_pkg::tag_type                    in_tag,
   input  logic [smau_pkg::OP_W-1:0]            op,
   input  logic signed [smau_pkg::DATA_W-1:0]   scale,
   input  logic signed [smau_pkg::DATA_W-1:0]   a_data,
   input  logic signed [smau_pkg::DATA_W-1:0]   b_data,
   output logic                                 stage_busy,
   output logic                                 out_vld,
   output smau_pkg::tag_type                    out_tag,
   output logic signed [smau_pkg::DATA_W-1:0]   out_result
);
   import smau_pkg::*;

   localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   function automatic logic signed [ACC_W-1:0] sat_term(input logic signed [TERM_W-1:0] v);
      if (v > TERM_W'(ACC_MAX)) return ACC_MAX;
      else if (v < TERM_W'(ACC_MIN)) return ACC_MIN;
      else return v[ACC_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W:0] v);
      if (v > (ACC_W+1)'(ACC_MAX)) return ACC_MAX;
      else if (v < (ACC_W+1)'(ACC_MIN)) return ACC_MIN;
      else return v[ACC_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(DATA_MAX)) return DATA_MAX;
      else if (v < ACC_W'(DATA_MIN)) return DATA_MIN;
      else return v[DATA_W-1:0];
   endfunction

   // stage M: one multiplier, or the add / pass path pre-scaled to Q32.32
   logic signed [DATA_W-1:0] mul_x;
   logic signed [DATA_W-1:0] mul_y;
   logic signed [PROD_W-1:0] pre_in;
   logic signed [PROD_W-1:0] pre_ff;
   logic                     m_vld_ff;
   tag_type                  m_tag_ff;

   // stage A: floor, clamp, accumulate, saturate
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  term_sat;
   logic signed [ACC_W-1:0]  acc_base;
   logic signed [ACC_W:0]    acc_sum;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     out_vld_ff;
   tag_type                  out_tag_ff;
   logic signed [DATA_W-1:0] result_ff;

   always_comb begin
      mul_x = (op == OP_SCALE) ? scale  : a_data;
      mul_y = (op == OP_SCALE) ? a_data : b_data;
      case (op)
         OP_ADD: begin
            pre_in = (PROD_W'(a_data) + PROD_W'(b_data)) <<< FRAC_W;
         end
         OP_TRANSPOSE: begin
            pre_in = PROD_W'(a_data) <<< FRAC_W;
         end
         default: begin
            pre_in = PROD_W'(mul_x) * PROD_W'(mul_y);
         end
      endcase
   end

   always_comb begin
      term     = $signed(pre_ff[PROD_W-1:FRAC_W]);
      term_sat = sat_term(term);
      acc_base = m_tag_ff.first ? '0 : acc_ff;
      acc_sum  = (ACC_W+1)'(acc_base) + (ACC_W+1)'(term_sat);
      acc_in   = sat_sum(acc_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         m_vld_ff   <= in_vld;
         out_vld_ff <= m_vld_ff && m_tag_ff.fin;
         if (m_vld_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pre_ff     <= pre_in;
      m_tag_ff   <= in_tag;
      out_tag_ff <= m_tag_ff;
      result_ff  <= sat_data(acc_in);
   end

   assign stage_busy = m_vld_ff;
   assign out_vld    = out_vld_ff;
   assign out_tag    = out_tag_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// ----- rtl/square_matrix_arithmetic_unit.sv -----
`default_nettype none

// Square matrix arithmetic unit: two matrices A and B (up to 8x8, signed Q16.16).
// Request beat: accepted when start is high and busy low. mode write A / write B
//   stores value at (row, col); the block is ready again next cycle.
// mode run: busy rises and the configured operation streams the n x n result out
//   in row-major order, one beat per rsp_valid pulse, last flagged on the final one.
// Result beats cannot be held off; each is valid for exactly one cycle.
// Add, elementwise, scale and transpose issue one element per cycle. Multiply
//   sends n terms per element through the single multiply-accumulate and
//   emits a result beat once the element's final term is accumulated.
// The datapath is: element RAM read (registered), 32x32 multiplier (registered),
//   floor/clamp/40-bit accumulate/saturate into the output register.
// An unknown operation code or mode 3 is accepted and produces nothing.
// Config: APB registers operation (0x0), dimension (0x4), scale_factor (0x8);
//   write only while idle. Reset returns registers to add / 8 / 1.0 and idles
//   the sequencer; matrix contents are undefined until written.
module square_matrix_arithmetic_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [smau_pkg::MODE_W-1:0]             req_mode,
   input  logic [smau_pkg::IDX_W-1:0]              req_row,
   input  logic [smau_pkg::IDX_W-1:0]              req_col,
   input  logic signed [smau_pkg::DATA_W-1:0]      req_value,
   output logic                                    rsp_valid,
   output logic [smau_pkg::IDX_W-1:0]              rsp_row_res,
   output logic [smau_pkg::IDX_W-1:0]              rsp_col_res,
   output logic signed [smau_pkg::DATA_W-1:0]      rsp_result,
   output logic                                    rsp_last,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [smau_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [smau_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [smau_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);
   import smau_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   function automatic logic [ADDR_W-1:0] elem_idx(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

   // ---------------- configuration registers ----------------
   logic                     csr_wr;
   logic [CSR_IDX_W-1:0]     csr_idx;
   logic [OP_W-1:0]          op_ff;
   logic [DIM_CFG_W-1:0]     dim_ff;
   logic signed [DATA_W-1:0] sf_ff;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= OP_ADD;
         dim_ff <= DIM_CFG_W'(MAX_DIM);
         sf_ff  <= SCALE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_OPERATION: op_ff  <= pwdata[OP_W-1:0];
            CSR_DIMENSION: dim_ff <= pwdata[DIM_CFG_W-1:0];
            CSR_SCALE:     sf_ff  <= $signed(pwdata[DATA_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_OPERATION: prdata = CSR_DATA_W'(op_ff);
         CSR_DIMENSION: prdata = CSR_DATA_W'(dim_ff);
         CSR_SCALE:     prdata = CSR_DATA_W'($unsigned(sf_ff));
         default:       prdata = '0;
      endcase
   end

   // ---------------- request decode ----------------
   logic             accept;
   logic             run_req;
   logic             in_range;
   logic             wr_a;
   logic             wr_b;
   logic [ADDR_W-1:0] wr_addr;
   logic [IDX_W-1:0] dim_last;  // clamped dimension minus one

   assign accept   = start && !busy;
   assign run_req  = accept && (req_mode == MODE_RUN) && (op_ff <= OP_TRANSPOSE);
   assign in_range = ({1'b0, req_row} < (IDX_W+1)'(MAX_DIM)) &&
                     ({1'b0, req_col} < (IDX_W+1)'(MAX_DIM));
   assign wr_a     = accept && (req_mode == MODE_WRITE_A) && in_range;
   assign wr_b     = accept && (req_mode == MODE_WRITE_B) && in_range;
   assign wr_addr  = elem_idx(req_row, req_col);

   always_comb begin
      if (dim_ff == '0) begin
         dim_last = '0;
      end else if (dim_ff > DIM_CFG_W'(MAX_DIM)) begin
         dim_last = IDX_W'(MAX_DIM - 1);
      end else begin
         dim_last = IDX_W'(dim_ff - 1'b1);
      end
   end

   // ---------------- sequencer: walks i, j and (for multiply) k ----------------
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] lim_ff, lim_in;
   logic             issue;
   logic             is_mul;
   tag_type          iss_tag;
   tag_type          s1_tag_ff;
   logic             s1_vld_ff;
   logic [ADDR_W-1:0] a_addr;
   logic [ADDR_W-1:0] b_addr;

   assign issue  = (state_ff == ST_RUN);
   assign is_mul = (op_ff == OP_MUL);

   always_comb begin
      iss_tag.row   = i_ff;
      iss_tag.col   = j_ff;
      iss_tag.first = (k_ff == '0);
      iss_tag.fin   = !is_mul || (k_ff == lim_ff);
      iss_tag.last  = iss_tag.fin && (i_ff == lim_ff) && (j_ff == lim_ff);

      if (is_mul) begin
         a_addr = elem_idx(i_ff, k_ff);
         b_addr = elem_idx(k_ff, j_ff);
      end else if (op_ff == OP_TRANSPOSE) begin
         a_addr = elem_idx(j_ff, i_ff);
         b_addr = elem_idx(i_ff, j_ff);
      end else begin
         a_addr = elem_idx(i_ff, j_ff);
         b_addr = elem_idx(i_ff, j_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      lim_in   = lim_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_req) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               lim_in   = dim_last;
            end
         end
         ST_RUN: begin
            if (!iss_tag.fin) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (j_ff == lim_ff) begin
                  j_in = '0;
                  if (i_ff == lim_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         lim_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         lim_ff    <= lim_in;
         s1_vld_ff <= issue;
      end
   end

   // tag aligned with the registered RAM read data
   always_ff @(posedge clock) begin
      s1_tag_ff <= iss_tag;
   end

   // ---------------- element stores ----------------
   logic [DATA_W-1:0] a_rd;
   logic [DATA_W-1:0] b_rd;

   smau_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_value)),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   smau_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_value)),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   // ---------------- shared multiply-accumulate ----------------
   logic    mac_busy;
   tag_type out_tag;

   smau_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (s1_vld_ff),
      .in_tag     (s1_tag_ff),
      .op         (op_ff),
      .scale      (sf_ff),
      .a_data     ($signed(a_rd)),
      .b_data     ($signed(b_rd)),
      .stage_busy (mac_busy),
      .out_vld    (rsp_valid),
      .out_tag    (out_tag),
      .out_result (rsp_result)
   );

   assign rsp_row_res = out_tag.row;
   assign rsp_col_res = out_tag.col;
   assign rsp_last    = out_tag.last;

   // busy until the last term has left the multiplier stage
   assign busy = (state_ff != ST_IDLE) || s1_vld_ff || mac_busy;

`ifndef SYNTH
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a run in progress");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result beat after the final element");

   a_run_goes_busy: assert property (@(posedge clock) disable iff (reset)
      run_req |=> busy)
      else $error("run beat did not raise busy");

   a_write_stays_ready: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_WRITE_A || req_mode == MODE_WRITE_B)) |=> !busy)
      else $error("element write left the block busy");

   a_counters_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (i_ff <= lim_ff && j_ff <= lim_ff && k_ff <= lim_ff))
      else $error("sequencer index beyond dimension");
`endif

endmodule

`default_nettype wire
